// ----- hdl/ptd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_pkg
// Types and constants shared by the periodic task dispatcher.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam logic [3:0] OP_ADD      = 4'd0;
  localparam logic [3:0] OP_DISPATCH = 4'd1;
  localparam logic [3:0] OP_SORT     = 4'd2;
  localparam logic [3:0] OP_FIND     = 4'd3;
  localparam logic [3:0] OP_SET_MODE = 4'd4;
  localparam logic [3:0] OP_SET_PER  = 4'd5;
  localparam logic [3:0] OP_SUSPEND  = 4'd6;
  localparam logic [3:0] OP_RUN_NOW  = 4'd7;
  localparam logic [3:0] OP_READ     = 4'd8;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_NO_TASK  = 3'd3;
  localparam logic [2:0] ST_NO_READY = 3'd4;

  localparam logic CFG_STRATEGY = 1'b0;
  localparam logic CFG_CAPACITY = 1'b1;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] now;
    logic [15:0] task_id;
    logic [3:0]  index;
    logic [31:0] period;
    logic [1:0]  run_kind;
    logic        rel_timing;
    logic [2:0]  priority_req;
    logic [31:0] delay_us;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        dispatched;
    logic [3:0]  task_slot;
    logic [15:0] found_id;
    logic        late;
    logic [31:0] peak_delay;
    logic [31:0] mean_delay;
    logic [31:0] delay_spread;
    logic [31:0] late_count;
  } rsp_t;

  // One table entry as held in the entry memory.
  typedef struct packed {
    logic [15:0] ident;
    logic [31:0] period;
    logic [31:0] due_time;
    logic [5:0]  mode_bits;
    logic [31:0] mean;
    logic [31:0] peak;
    logic [31:0] spread;
    logic [31:0] late_total;
  } entry_t;

endpackage
`default_nettype wire

// ----- hdl/ptd_stream_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_stream_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface ptd_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/periodic_task_dispatcher_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_top
// Table of periodic tasks with dispatch, sort, find and per-task controls.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req (valid/ready); each gives exactly one response
//   on rsp. Registers are written on cfg_we/cfg_index/cfg_data; the user
//   must write them only while idle, as the block does not enforce it.
//   The table lives in one synchronous memory; each request is handled
//   by a sequencer that reads, modifies and writes back entries one at a
//   time. A rejected op or a full table is answered from idle; set and
//   read ops read, modify and write one slot; add scans all used slots
//   for a duplicate; find stops at the first hit; dispatch scans from the
//   scan start to the first ready slot, then waits for the statistics
//   unit; sort is an insertion sort over the used slots.
//   One request is in work at a time. req.ready is high only while the
//   sequencer is idle and the response register is empty or being taken
//   in that cycle, so a stalled receiver holds off the next request.
//   Reset clears used count, scan start and registers (strategy 0,
//   capacity 16); table contents are undefined until a task is added.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher_top #(
  parameter int MAX_TASKS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  ptd_stream_if.sink       req,
  ptd_stream_if.source     rsp,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [4:0]  cfg_data
);
  import ptd_pkg::*;

  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN_RD = 4'd1;
  localparam logic [3:0] S_SCAN_CK = 4'd2;
  localparam logic [3:0] S_SLOT    = 4'd3;
  localparam logic [3:0] S_MODIFY  = 4'd4;
  localparam logic [3:0] S_STATS   = 4'd5;
  localparam logic [3:0] S_ANSWER  = 4'd6;
  localparam logic [3:0] S_ANS_CK  = 4'd7;
  localparam logic [3:0] S_SORT_A  = 4'd8;
  localparam logic [3:0] S_SORT_B  = 4'd9;
  localparam logic [3:0] S_SORT_C  = 4'd10;
  localparam logic [3:0] S_SORT_W  = 4'd11;
  localparam logic [3:0] S_EMIT    = 4'd12;
  localparam logic [3:0] S_SORT_D  = 4'd13;
  localparam logic [3:0] S_SORT_R  = 4'd14;

  entry_t mem [MAX_TASKS];
  entry_t rd_data;
  logic [AW-1:0] rd_addr;
  logic rd_en;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  entry_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  logic [3:0]    state;
  req_t          cur;
  logic          strategy;
  logic [4:0]    task_capacity;
  logic [CW-1:0] used_count;
  logic [AW-1:0] scan_start;
  logic [CW-1:0] k;
  logic [AW-1:0] slot;
  logic [AW-1:0] sj;
  logic [CW-1:0] si;
  entry_t        ent;
  entry_t        ent_b;
  entry_t        upd;
  logic          late;
  logic          rsp_valid;
  rsp_t          rsp_data;
  logic          stats_start;
  logic          stats_done;
  logic [31:0]   stats_delay;
  logic [31:0]   mean_n;
  logic [31:0]   peak_n;
  logic [31:0]   spread_n;
  logic [CW-1:0] cap;
  logic [AW-1:0] start_slot;
  logic [AW-1:0] cur_slot;
  logic          idx_ok;
  logic          ready_hit;
  logic [31:0]   nr_adv;

  assign cap = (int'(task_capacity) >= MAX_TASKS) ? CW'(MAX_TASKS) : CW'(task_capacity);
  assign start_slot = (CW'(scan_start) < used_count) ? scan_start : '0;
  assign idx_ok = int'(cur.index) < int'(used_count);
  assign ready_hit = (rd_data.mode_bits[1:0] != 2'd0) && (cur.now >= rd_data.due_time);
  assign nr_adv = ent.mode_bits[2] ? cur.now + ent.period : ent.due_time + ent.period;

  // Next slot in circular scan order.
  always_comb begin
    logic [CW:0] t;
    t = (CW+1)'(start_slot) + (CW+1)'(k);
    if (t >= {1'b0, used_count}) begin
      t = t - {1'b0, used_count};
    end
    cur_slot = t[AW-1:0];
  end

  // Updated entry for the single-slot operations.
  always_comb begin
    upd = rd_data;
    case (cur.op)
      OP_SET_MODE: upd.mode_bits[1:0] = cur.run_kind;
      OP_SET_PER: begin
        upd.period = cur.period;
        upd.mode_bits[1:0] = 2'd2;
        upd.due_time = cur.now;
      end
      OP_SUSPEND: upd.due_time = cur.now + cur.delay_us;
      OP_RUN_NOW: begin
        if (upd.mode_bits[1:0] == 2'd0) begin
          upd.mode_bits[0] = 1'b1;
        end
        upd.due_time = cur.now;
      end
      default: ;
    endcase
  end

  assign req.ready = (state == S_IDLE) && (!rsp_valid || rsp.ready);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  ptd_stats u_stats (
    .clk        (clk),
    .rst        (rst),
    .start      (stats_start),
    .delay      (stats_delay),
    .mean_in    (ent.mean),
    .peak_in    (ent.peak),
    .spread_in  (ent.spread),
    .done       (stats_done),
    .mean_out   (mean_n),
    .peak_out   (peak_n),
    .spread_out (spread_n)
  );

  function automatic rsp_t fail(input logic [2:0] st);
    rsp_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  function automatic rsp_t ok_rsp(input entry_t e, input logic [3:0] s, input logic d,
                                  input logic lt);
    rsp_t r;
    r = '0;
    r.status       = ST_OK;
    r.dispatched   = d;
    r.task_slot    = s;
    r.found_id     = e.ident;
    r.late         = lt;
    r.peak_delay   = e.peak;
    r.mean_delay   = e.mean;
    r.delay_spread = e.spread;
    r.late_count   = e.late_total;
    return r;
  endfunction

  always_comb begin
    rd_en = 1'b0;
    rd_addr = '0;
    case (state)
      S_SCAN_RD: begin
        rd_en = 1'b1;
        rd_addr = (cur.op == OP_DISPATCH) ? cur_slot : k[AW-1:0];
      end
      S_SLOT: begin
        rd_en = 1'b1;
        rd_addr = AW'(cur.index);
      end
      S_ANSWER: begin
        rd_en = 1'b1;
        rd_addr = slot;
      end
      S_SORT_A: begin
        rd_en = 1'b1;
        rd_addr = sj;
      end
      S_SORT_B, S_SORT_R: begin
        rd_en = 1'b1;
        rd_addr = sj - AW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      strategy <= 1'b0;
      task_capacity <= 5'd16;
      used_count <= '0;
      scan_start <= '0;
      rsp_valid <= 1'b0;
      stats_start <= 1'b0;
      wr_en <= 1'b0;
    end else begin
      wr_en <= 1'b0;
      stats_start <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_STRATEGY) begin
          strategy <= cfg_data[0];
        end else begin
          task_capacity <= cfg_data;
        end
      end
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur <= req.data;
            k <= '0;
            case (req.data.op)
              OP_ADD: begin
                if (used_count >= cap) begin
                  rsp_data <= fail(ST_FULL);
                  rsp_valid <= 1'b1;
                end else begin
                  state <= S_SCAN_RD;
                end
              end
              OP_DISPATCH, OP_FIND: begin
                state <= S_SCAN_RD;
              end
              OP_SORT: begin
                si <= CW'(1);
                state <= S_SORT_W;
              end
              OP_SET_MODE, OP_SET_PER, OP_SUSPEND, OP_RUN_NOW, OP_READ: begin
                state <= S_SLOT;
              end
              default: begin
                rsp_data <= fail(ST_NO_TASK);
                rsp_valid <= 1'b1;
              end
            endcase
          end
        end
        // Walk used slots; the check state sees the read data.
        S_SCAN_RD: begin
          if (k >= used_count) begin
            state <= S_IDLE;
            if (cur.op == OP_ADD) begin
              wr_en <= 1'b1;
              wr_addr <= AW'(used_count);
              wr_data <= '{ident: cur.task_id, period: cur.period, due_time: cur.now,
                           mode_bits: {cur.priority_req, cur.rel_timing, cur.run_kind},
                           mean: '0, peak: '0, spread: '0, late_total: '0};
              used_count <= used_count + CW'(1);
              rsp_data <= '{status: ST_OK, dispatched: 1'b0,
                            task_slot: 4'(used_count), found_id: cur.task_id, late: 1'b0,
                            peak_delay: '0, mean_delay: '0, delay_spread: '0,
                            late_count: '0};
              rsp_valid <= 1'b1;
            end else if (cur.op == OP_FIND) begin
              rsp_data <= fail(ST_NO_TASK);
              rsp_valid <= 1'b1;
            end else begin
              scan_start <= '0;
              rsp_data <= fail(ST_NO_READY);
              rsp_valid <= 1'b1;
            end
          end else begin
            slot <= (cur.op == OP_DISPATCH) ? cur_slot : k[AW-1:0];
            state <= S_SCAN_CK;
          end
        end
        S_SCAN_CK: begin
          k <= k + CW'(1);
          state <= S_SCAN_RD;
          if (cur.op == OP_DISPATCH) begin
            if (ready_hit) begin
              ent <= rd_data;
              stats_delay <= cur.now - rd_data.due_time;
              state <= S_MODIFY;
            end
          end else if (rd_data.ident == cur.task_id) begin
            state <= S_IDLE;
            if (cur.op == OP_ADD) begin
              rsp_data <= fail(ST_DUP);
            end else begin
              rsp_data <= ok_rsp(rd_data, 4'(slot), 1'b0, 1'b0);
            end
            rsp_valid <= 1'b1;
          end
        end
        // Advance next-run time, then hand delay to the statistics unit.
        S_MODIFY: begin
          if (ent.mode_bits[1:0] == 2'd1) begin
            ent.mode_bits[1:0] <= 2'd0;
          end
          if (nr_adv < cur.now) begin
            late <= 1'b1;
            ent.late_total <= ent.late_total + 32'd1;
            ent.due_time <= cur.now + ent.period;
          end else begin
            late <= 1'b0;
            ent.due_time <= nr_adv;
          end
          stats_start <= 1'b1;
          state <= S_STATS;
        end
        S_STATS: begin
          if (stats_done) begin
            wr_en <= 1'b1;
            wr_addr <= slot;
            wr_data <= '{ident: ent.ident, period: ent.period, due_time: ent.due_time,
                         mode_bits: ent.mode_bits, mean: mean_n, peak: peak_n,
                         spread: spread_n, late_total: ent.late_total};
            rsp_data <= '{status: ST_OK, dispatched: 1'b1, task_slot: 4'(slot),
                          found_id: ent.ident, late: late, peak_delay: peak_n,
                          mean_delay: mean_n, delay_spread: spread_n,
                          late_count: ent.late_total};
            rsp_valid <= 1'b1;
            if (strategy && (CW'(slot) + CW'(1) < used_count)) begin
              scan_start <= slot + AW'(1);
            end else begin
              scan_start <= '0;
            end
            state <= S_IDLE;
          end
        end
        S_SLOT: begin
          if (!idx_ok) begin
            rsp_data <= fail(ST_NO_TASK);
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            slot <= AW'(cur.index);
            state <= S_ANSWER;
          end
        end
        // Read-modify-write of one addressed slot.
        S_ANSWER: begin
          state <= S_ANS_CK;
        end
        S_ANS_CK: begin
          wr_en <= 1'b1;
          wr_addr <= slot;
          wr_data <= upd;
          rsp_data <= ok_rsp(upd, 4'(slot), 1'b0, 1'b0);
          rsp_valid <= 1'b1;
          state <= S_IDLE;
        end
        // Insertion sort: si is the outer index, sj walks down.
        S_SORT_W: begin
          if (si >= used_count) begin
            rsp_data <= fail(ST_OK);
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            sj <= si[AW-1:0];
            state <= S_SORT_A;
          end
        end
        S_SORT_A: begin
          state <= S_SORT_B;
        end
        S_SORT_B: begin
          ent_b <= rd_data;
          state <= S_SORT_C;
        end
        // Read slot sj-1 only; ent_b still holds the moving entry.
        S_SORT_R: begin
          state <= S_SORT_C;
        end
        S_SORT_C: begin
          ent <= rd_data;
          state <= S_EMIT;
        end
        S_EMIT: begin
          // ent holds slot sj-1, ent_b holds the entry moving down from sj.
          if ((ent_b.mode_bits[5:3] != ent.mode_bits[5:3])
              ? (ent_b.mode_bits[5:3] > ent.mode_bits[5:3])
              : (ent_b.period < ent.period)) begin
            wr_en <= 1'b1;
            wr_addr <= sj;
            wr_data <= ent;
            state <= S_SORT_D;
          end else begin
            si <= si + CW'(1);
            state <= S_SORT_W;
          end
        end
        // Second half of the swap: drop the moving entry into slot sj-1.
        S_SORT_D: begin
          wr_en <= 1'b1;
          wr_addr <= sj - AW'(1);
          wr_data <= ent_b;
          if (sj == AW'(1)) begin
            si <= si + CW'(1);
            state <= S_SORT_W;
          end else begin
            sj <= sj - AW'(1);
            state <= S_SORT_R;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold the response while the receiver stalls.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ready |=> rsp_valid && $stable(rsp_data))
    else $error("response changed while stalled");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CW'(MAX_TASKS))
    else $error("used count beyond table size");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !req.ready)
    else $error("request accepted while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != ST_OK |-> rsp_data.dispatched == 1'b0)
    else $error("failed response carries dispatch");
endmodule
`default_nettype wire

// ----- hdl/ptd_stats.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_stats
// Delay statistics update: mean and peak, then |d|, d*d and spread in turn.
// ----------------------------------------------------------------------------
module ptd_stats (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] delay,
  input  wire logic [31:0] mean_in,
  input  wire logic [31:0] peak_in,
  input  wire logic [31:0] spread_in,
  output logic             done,
  output logic [31:0]      mean_out,
  output logic [31:0]      peak_out,
  output logic [31:0]      spread_out
);
  logic [2:0]  stage;
  logic [31:0] dly;
  logic [31:0] d;
  logic [31:0] sq;
  logic [31:0] sp15;
  logic [31:0] mean7;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= 3'd0;
    end else begin
      stage <= {stage[1:0], start};
    end
  end

  assign mean7 = (mean_in << 3) - mean_in;

  always_ff @(posedge clk) begin
    if (start) begin
      dly      <= delay;
      mean_out <= (mean7 + delay) >> 3;
      peak_out <= (delay > peak_in) ? delay : peak_in;
      sp15     <= (spread_in << 4) - spread_in;
    end
    if (stage[0]) begin
      d <= (dly >= mean_out) ? dly - mean_out : mean_out - dly;
    end
    if (stage[1]) begin
      sq <= d * d;
    end
    if (stage[2]) begin
      spread_out <= (sp15 + sq) >> 4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage[2];
    end
  end
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the periodic task dispatcher: requests are driven
// on the request channel, each accepted request is run through a local model
// of the task table, and every response is compared with the oldest
// prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ptd_pkg::*;

  localparam int SLOTS      = 16;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 400;
  localparam int RAND_ITEMS = 260;

  // --------------------------------------------------------------------------
  // Task table model and response scoreboard
  // --------------------------------------------------------------------------
  class task_table_board;
    entry_t     tbl[SLOTS];
    int         used;
    int         scan;
    bit         strat;
    logic [4:0] cap;
    rsp_t       pending[$];
    int         mismatches;

    function new();
      used = 0;
      scan = 0;
      strat = 0;
      cap = 5'd16;
      mismatches = 0;
    endfunction

    function void write_reg(logic idx, logic [4:0] val);
      if (idx == CFG_STRATEGY) strat = val[0];
      else cap = val;
    endfunction

    function rsp_t reply(logic [2:0] st, logic disp, int slot, logic lt);
      rsp_t r;
      r = '0;
      r.status = st;
      if (st != ST_OK || slot >= SLOTS) return r;
      r.dispatched   = disp;
      r.task_slot    = slot[3:0];
      r.found_id     = tbl[slot].ident;
      r.late         = lt;
      r.peak_delay   = tbl[slot].peak;
      r.mean_delay   = tbl[slot].mean;
      r.delay_spread = tbl[slot].spread;
      r.late_count   = tbl[slot].late_total;
      return r;
    endfunction

    function bit ranks_higher(int a, int b);
      if (tbl[a].mode_bits[5:3] != tbl[b].mode_bits[5:3])
        return tbl[a].mode_bits[5:3] > tbl[b].mode_bits[5:3];
      return tbl[a].period < tbl[b].period;
    endfunction

    function rsp_t dispatch_one(logic [31:0] now);
      int start, i;
      logic [31:0] dly, d, acc;
      logic lt;
      start = (scan < used) ? scan : 0;
      for (int k = 0; k < used; k++) begin
        i = start + k;
        if (i >= used) i -= used;
        if (tbl[i].mode_bits[1:0] == 2'd0 || now < tbl[i].due_time) continue;
        dly = now - tbl[i].due_time;
        if (tbl[i].mode_bits[2]) tbl[i].due_time = now + tbl[i].period;
        else tbl[i].due_time = tbl[i].due_time + tbl[i].period;
        if (tbl[i].mode_bits[1:0] == 2'd1) tbl[i].mode_bits[1:0] = 2'd0;
        lt = 1'b0;
        if (tbl[i].due_time < now) begin
          lt = 1'b1;
          tbl[i].late_total = tbl[i].late_total + 1;
          tbl[i].due_time = now + tbl[i].period;
        end
        acc = 32'd7 * tbl[i].mean + dly;
        tbl[i].mean = acc / 8;
        if (dly > tbl[i].peak) tbl[i].peak = dly;
        d = (dly >= tbl[i].mean) ? dly - tbl[i].mean : tbl[i].mean - dly;
        acc = 32'd15 * tbl[i].spread + d * d;
        tbl[i].spread = acc / 16;
        if (strat) scan = (i + 1 >= used) ? 0 : i + 1;
        else scan = 0;
        return reply(ST_OK, 1'b1, i, lt);
      end
      scan = 0;
      return reply(ST_NO_READY, 1'b0, 0, 1'b0);
    endfunction

    // Work out the response to one accepted request and queue it.
    function void note_request(req_t q);
      int limit, idx;
      entry_t t;
      rsp_t r;
      limit = (cap < SLOTS) ? cap : SLOTS;
      idx = q.index;
      r = reply(ST_NO_TASK, 1'b0, 0, 1'b0);
      case (q.op)
        OP_ADD: begin
          if (used >= limit) begin
            r = reply(ST_FULL, 1'b0, 0, 1'b0);
          end else begin
            r.status = ST_OK;
            for (int i = 0; i < used; i++)
              if (tbl[i].ident == q.task_id) r = reply(ST_DUP, 1'b0, 0, 1'b0);
            if (r.status == ST_OK) begin
              t = '0;
              t.ident = q.task_id;
              t.period = q.period;
              t.due_time = q.now;
              t.mode_bits = {q.priority_req, q.rel_timing, q.run_kind};
              tbl[used] = t;
              used++;
              r = reply(ST_OK, 1'b0, used - 1, 1'b0);
            end
          end
        end
        OP_DISPATCH: r = dispatch_one(q.now);
        OP_SORT: begin
          for (int i = 1; i < used; i++)
            for (int j = i; j > 0 && ranks_higher(j, j - 1); j--) begin
              t = tbl[j];
              tbl[j] = tbl[j - 1];
              tbl[j - 1] = t;
            end
          r = reply(ST_OK, 1'b0, SLOTS, 1'b0);
        end
        OP_FIND: begin
          for (int i = used - 1; i >= 0; i--)
            if (tbl[i].ident == q.task_id) r = reply(ST_OK, 1'b0, i, 1'b0);
        end
        OP_SET_MODE, OP_SET_PER, OP_SUSPEND, OP_RUN_NOW, OP_READ: begin
          if (idx < used) begin
            case (q.op)
              OP_SET_MODE: tbl[idx].mode_bits[1:0] = q.run_kind;
              OP_SET_PER: begin
                tbl[idx].period = q.period;
                tbl[idx].mode_bits[1:0] = 2'd2;
                tbl[idx].due_time = q.now;
              end
              OP_SUSPEND: tbl[idx].due_time = q.now + q.delay_us;
              OP_RUN_NOW: begin
                if (tbl[idx].mode_bits[1:0] == 2'd0) tbl[idx].mode_bits[0] = 1'b1;
                tbl[idx].due_time = q.now;
              end
              default: ;
            endcase
            r = reply(ST_OK, 1'b0, idx, 1'b0);
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_r, got);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [4:0] cfg_data = '0;

  ptd_stream_if #(.T(req_t)) req_ch ();
  ptd_stream_if #(.T(rsp_t)) rsp_ch ();

  periodic_task_dispatcher_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch.sink),
    .rsp      (rsp_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  task_table_board board = new();
  int  activity = 0;   // bumped on every accepted request or response
  bit  quiet_phase = 0; // when set, neither side idles
  logic [31:0] clock_us = 0;

  // Mostly short gaps, a few long ones.
  function int pick_gap();
    int p;
    if (quiet_phase) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Response side: stall at random, check every accepted response
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    stall = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        rsp_ch.ready <= 1'b0;
      end else begin
        stall = pick_gap();
        rsp_ch.ready <= (stall == 0);
      end
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        board.check_response(rsp_ch.data);
        activity++;
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  initial begin
    int idle_cycles, last;
    idle_cycles = 0;
    last = 0;
    forever begin
      @(posedge clk);
      if (activity != last) idle_cycles = 0;
      else idle_cycles++;
      last = activity;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Offer one request after a random gap; hold it until accepted.
  task send_request(req_t q);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.data  <= q;
    do @(posedge clk); while (!req_ch.ready);
    board.note_request(q);
    activity++;
  endtask

  // Drop valid, drain every outstanding response, then let a sort finish.
  task wait_idle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task write_reg(logic idx, logic [4:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, val);
  endtask

  // Fully random content; callers override what matters.
  function req_t noise_req();
    req_t q;
    q.op           = 4'($urandom);
    q.now          = $urandom;
    q.task_id      = 16'($urandom);
    q.index        = 4'($urandom);
    q.period       = $urandom;
    q.run_kind     = 2'($urandom);
    q.rel_timing   = 1'($urandom);
    q.priority_req = 3'($urandom);
    q.delay_us     = $urandom;
    return q;
  endfunction

  function req_t make_req(logic [3:0] op, logic [31:0] now, logic [15:0] id,
                          logic [3:0] idx, logic [31:0] per, logic [1:0] rm,
                          logic tm, logic [2:0] pr, logic [31:0] dly);
    req_t q;
    q = '{op, now, id, idx, per, rm, tm, pr, dly};
    return q;
  endfunction

  // A plausible scheduler request: time mostly moves forward, small id pool,
  // indexes mostly in use, periods mostly modest.
  function req_t sched_req();
    req_t q;
    int p;
    q = noise_req();
    if ($urandom_range(0, 99) < 3) clock_us = $urandom;
    else clock_us = clock_us + $urandom_range(0, 400);
    q.now = clock_us;
    p = $urandom_range(0, 99);
    if (p < 18) q.op = OP_ADD;
    else if (p < 58) q.op = OP_DISPATCH;
    else if (p < 62) q.op = OP_SORT;
    else if (p < 68) q.op = OP_FIND;
    else if (p < 74) q.op = OP_SET_MODE;
    else if (p < 80) q.op = OP_SET_PER;
    else if (p < 86) q.op = OP_SUSPEND;
    else if (p < 92) q.op = OP_RUN_NOW;
    else if (p < 98) q.op = OP_READ;
    if ($urandom_range(0, 9) != 0) q.task_id = 16'($urandom_range(0, 40));
    if ($urandom_range(0, 9) != 0 && board.used > 0)
      q.index = 4'($urandom_range(0, board.used - 1));
    if ($urandom_range(0, 19) != 0) q.period = $urandom_range(0, 2000);
    if ($urandom_range(0, 19) != 0) q.delay_us = $urandom_range(0, 3000);
    if (q.run_kind == 2'd0 && $urandom_range(0, 2) != 0) q.run_kind = 2'd2;
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    bit [5:0] settings[6];
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    settings = '{ {1'b1, 5'd16}, {1'b0, 5'd31}, {1'b1, 5'd5},
                  {1'b0, 5'd16}, {1'b1, 5'd31}, {1'b0, 5'd1} };
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty table with no room: adds fail, nothing is ready, no task found.
    write_reg(CFG_STRATEGY, 5'd0);
    write_reg(CFG_CAPACITY, 5'd0);
    send_request(make_req(OP_ADD, 0, 7, 0, 10, 2, 0, 3, 0));
    send_request(make_req(OP_DISPATCH, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(OP_FIND, 0, 7, 0, 0, 0, 0, 0, 0));
    send_request(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(4'd15, 0, 0, 4'd15, 0, 0, 0, 0, 0));
    wait_idle();

    // Directed table work: extremes, duplicates, every op, a late task.
    write_reg(CFG_CAPACITY, 5'd16);
    send_request(make_req(OP_ADD, 0, 16'h0000, 0, 32'hFFFF_FFFF, 2, 0, 7, 0));
    send_request(make_req(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, 0, 0, 3, 1, 0, 0));
    send_request(make_req(OP_ADD, 5, 16'h0000, 0, 1, 1, 0, 2, 0));
    send_request(make_req(OP_ADD, 0, 16'h0011, 0, 1, 2, 0, 2, 0));
    send_request(make_req(OP_ADD, 0, 16'h0022, 0, 50, 1, 1, 2, 0));
    send_request(make_req(OP_FIND, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0));
    send_request(make_req(OP_FIND, 0, 16'h1234, 0, 0, 0, 0, 0, 0));
    send_request(make_req(OP_DISPATCH, 1000, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(OP_DISPATCH, 1000, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(OP_DISPATCH, 1000, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(OP_SET_MODE, 0, 0, 4, 0, 0, 0, 0, 0));
    send_request(make_req(OP_SET_PER, 2000, 0, 2, 32'h8000_0000, 0, 0, 0, 0));
    send_request(make_req(OP_SUSPEND, 32'hFFFF_FFF0, 0, 3, 0, 0, 0, 0,
                          32'hFFFF_FFFF));
    send_request(make_req(OP_RUN_NOW, 3000, 0, 4, 0, 0, 0, 0, 0));
    send_request(make_req(OP_READ, 0, 0, 3, 0, 0, 0, 0, 0));
    send_request(make_req(OP_READ, 0, 0, 4'd15, 0, 0, 0, 0, 0));
    send_request(make_req(OP_SORT, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(OP_DISPATCH, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(4'd9, 0, 0, 0, 0, 0, 0, 0, 0));
    wait_idle();

    // Random phases, one register setting each; the first runs without gaps.
    clock_us = 4000;
    foreach (settings[s]) begin
      write_reg(CFG_STRATEGY, {4'd0, settings[s][5]});
      write_reg(CFG_CAPACITY, settings[s][4:0]);
      quiet_phase = (s == 0);
      for (int n = 0; n < RAND_ITEMS * 5 / 6; n++) begin
        if ($urandom_range(0, 99) < 5) send_request(noise_req());
        else send_request(sched_req());
      end
      wait_idle();
      quiet_phase = 0;
    end

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
